FILE: design/wrlv_pkg.sv
// Package for the write range list validator.
// Holds limits, widths, status codes and controller states.
// No dependencies.
`default_nettype none

package wrlv_pkg;

    localparam int unsigned MAX_RANGES      = 4096;
    localparam int unsigned SECTOR_BYTES    = 512;
    localparam int unsigned MAX_RANGE_BYTES = 16777216;
    localparam int unsigned MAX_TOTAL_BYTES = 67108864;
    localparam int unsigned MAX_LABEL_BYTES = 4096;

    localparam int unsigned IDX_W   = $clog2(MAX_RANGES);
    localparam int unsigned CNT_W   = $clog2(MAX_RANGES + 1);
    localparam int unsigned TOTAL_W = 27;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 64;

    // register indexes, one 8-byte slot each
    localparam logic REG_DEVICE_SIZE = 1'b0;
    localparam logic REG_RANGE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_COUNT   = 3'd1,
        ST_LENGTHS = 3'd2,
        ST_BOUNDS  = 3'd3,
        ST_LABEL   = 3'd4,
        ST_TOTAL   = 3'd5,
        ST_OVERLAP = 3'd6,
        ST_SKIPPED = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } fsm_t;

endpackage

`default_nettype wire

FILE: design/wrlv_if.sv
// Handshake channels of the write range list validator.
// wrlv_item_if carries one range, wrlv_result_if one result. Uses wrlv_pkg.
`default_nettype none

interface wrlv_item_if;
    logic        valid;
    logic        ready;
    logic        first_of_list;
    logic [63:0] range_offset;
    logic [31:0] before_length;
    logic [31:0] after_length;
    logic [15:0] label_len;

    modport source (output valid, first_of_list, range_offset, before_length,
                    after_length, label_len, input ready);
    modport sink   (input valid, first_of_list, range_offset, before_length,
                    after_length, label_len, output ready);
endinterface

interface wrlv_result_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [wrlv_pkg::TOTAL_W-1:0] captured_total;

    modport source (output valid, status, captured_total, input ready);
    modport sink   (input valid, status, captured_total, output ready);
endinterface

`default_nettype wire

FILE: design/wrlv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wrlv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/write_range_list_validator.sv
// Write range list validator: top level with APB registers, controller
// and the range store. Depends on wrlv_pkg, wrlv_if.sv and wrlv_ram.
//
// Each input word is one write range; one result word comes back per range.
// A range is taken, checked against the count, length, alignment, device,
// label and total limits by combinational logic, and then compared against
// every range already accepted in the current list by reading the range store
// one entry per cycle. An item that passes the limit checks while N ranges
// (1 to 4095) are already accepted in the list is compared against each of
// them in turn: the store's single registered read port sets the scan, and a
// hit stops the scan early. Items that fail a limit check, are skipped, or
// meet an empty list go from the check straight to the result, with no scan.
// One item is worked on at a time; the next is taken once the result has
// moved into the output register, so a stalled result holds the following
// item in its last cycle. The store needs no clearing after reset: only
// entries below the accepted count are ever read. Registers (64-bit APB data):
// device size at 0x0, range count at 0x8; write them only while idle.
`default_nettype none

module write_range_list_validator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wrlv_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [wrlv_pkg::DATA_W-1:0]   pwdata,
    output logic      [wrlv_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    wrlv_item_if.sink                          in_item,
    wrlv_result_if.source                      out_res
);

    import wrlv_pkg::*;

    // configuration
    logic [63:0] dev_size_reg;
    logic [15:0] rcount_reg;
    logic        cfg_wr;

    // item payload
    logic [63:0] off_reg;
    logic [31:0] before_reg;
    logic [31:0] after_reg;
    logic [15:0] label_reg;
    logic [63:0] end_reg, end_next;

    // list state and controller
    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               failed_reg, failed_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               pend_reg, pend_next;
    status_t            result_reg, result_next;

    // output stage
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;

    // store ports
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [127:0]     ram_rdata;
    logic [63:0]      rd_start, rd_end;

    logic        in_fire;
    logic        out_free;
    status_t     check_status;
    logic [32:0] total_sum;
    logic [63:0] room;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3])
            REG_DEVICE_SIZE: prdata = dev_size_reg;
            REG_RANGE_COUNT: prdata = {48'd0, rcount_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_size_reg <= '0;
            rcount_reg   <= 16'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                REG_DEVICE_SIZE: dev_size_reg <= pwdata;
                REG_RANGE_COUNT: rcount_reg   <= pwdata[15:0];
                default:         dev_size_reg <= dev_size_reg;
            endcase
        end
    end

    assign in_item.ready      = (state_reg == S_IDLE);
    assign in_fire            = in_item.valid && in_item.ready;
    assign out_res.valid      = out_valid_reg;
    assign out_res.status     = out_status_reg;
    assign out_res.captured_total = out_total_reg;
    assign out_free           = !out_valid_reg || out_res.ready;

    assign rd_start = ram_rdata[63:0];
    assign rd_end   = ram_rdata[127:64];

    // combinational limit checks on the held range
    assign total_sum = {6'd0, total_reg} + {1'b0, before_reg};
    assign room      = dev_size_reg - off_reg;

    always_comb
    begin
        priority if (rcount_reg == 16'd0 || 32'(rcount_reg) > MAX_RANGES ||
                     16'(acc_reg) >= rcount_reg)
        begin
            check_status = ST_COUNT;
        end
        else if (before_reg == 32'd0 || before_reg != after_reg)
        begin
            check_status = ST_LENGTHS;
        end
        else if (before_reg > 32'(MAX_RANGE_BYTES) ||
                 (off_reg % 64'(SECTOR_BYTES)) != 64'd0 ||
                 (before_reg % 32'(SECTOR_BYTES)) != 32'd0 ||
                 off_reg > dev_size_reg || {32'd0, before_reg} > room)
        begin
            check_status = ST_BOUNDS;
        end
        else if (label_reg > 16'(MAX_LABEL_BYTES))
        begin
            check_status = ST_LABEL;
        end
        else if (total_sum > 33'(MAX_TOTAL_BYTES))
        begin
            check_status = ST_TOTAL;
        end
        else
        begin
            check_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        total_next      = total_reg;
        failed_next     = failed_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        result_next     = result_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = scan_reg[IDX_W-1:0];

        if (out_valid_reg && out_res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_item.first_of_list)
                    begin
                        acc_next    = '0;
                        total_next  = '0;
                        failed_next = 1'b0;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                end_next  = off_reg + {32'd0, before_reg};
                scan_next = '0;
                pend_next = 1'b0;
                if (failed_reg)
                begin
                    result_next = ST_SKIPPED;
                    state_next  = S_DONE;
                end
                else if (check_status != ST_OK || acc_reg == '0)
                begin
                    result_next = check_status;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // compare the entry read last cycle, issue the next read
                if (pend_reg && off_reg < rd_end && rd_start < end_reg)
                begin
                    result_next = ST_OVERLAP;
                    state_next  = S_DONE;
                end
                else if (scan_reg < acc_reg)
                begin
                    ram_re    = 1'b1;
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next   = 1'b0;
                    result_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (result_reg == ST_OK)
                    begin
                        ram_we     = (32'(acc_reg) < MAX_RANGES);
                        acc_next   = ram_we ? acc_reg + 1'b1 : acc_reg;
                        total_next = total_sum[TOTAL_W-1:0];
                    end
                    else if (result_reg != ST_SKIPPED)
                    begin
                        failed_next = 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = result_reg;
                    out_total_next  = (result_reg == ST_OK) ? total_sum[TOTAL_W-1:0]
                                                            : total_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            total_reg     <= '0;
            failed_reg    <= 1'b0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            failed_reg    <= failed_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            off_reg    <= in_item.range_offset;
            before_reg <= in_item.before_length;
            after_reg  <= in_item.after_length;
            label_reg  <= in_item.label_len;
        end
        end_reg        <= end_next;
        result_reg     <= result_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

    // range store: end in the upper half, start in the lower half
    wrlv_ram #(
        .WIDTH (128),
        .DEPTH (MAX_RANGES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (acc_reg[IDX_W-1:0]),
        .wdata ({end_reg, off_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for write_range_list_validator: directed and random range lists,
// checked word by word against a predictor of the list checks.
// Depends on wrlv_pkg, wrlv_if.sv and the design files.
`default_nettype none

module tb_top;
    import wrlv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 110;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 64;

    typedef struct {
        bit          first_of_list;
        logic [63:0] range_offset;
        logic [31:0] before_length;
        logic [31:0] after_length;
        logic [15:0] label_len;
    } range_word_t;

    typedef struct {
        status_t            status;
        logic [TOTAL_W-1:0] total;
    } range_verdict_t;

    // Tracks the accepted ranges of the open list and the verdicts owed.
    class range_list_tracker;
        logic [63:0]        dev_bytes;
        logic [15:0]        list_len;
        logic [63:0]        taken_start_q[$];
        logic [63:0]        taken_stop_q[$];
        logic [TOTAL_W-1:0] byte_sum;
        bit                 list_failed;
        range_verdict_t     verdict_q[$];
        int                 errors;
        int                 ranges_seen;
        int                 lists_seen;
        int                 settings_used;
        int                 status_hits[8];

        function new();
            dev_bytes     = '0;
            list_len      = 16'd1;
            byte_sum      = '0;
            list_failed   = 1'b0;
            errors        = 0;
            ranges_seen   = 0;
            lists_seen    = 0;
            settings_used = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function status_t judge_range(range_word_t w);
            longint unsigned start;
            longint unsigned blen;
            longint unsigned alen;
            longint unsigned stop;
            longint unsigned sum;
            start = w.range_offset;
            blen  = 64'(w.before_length);
            alen  = 64'(w.after_length);
            sum   = 64'(byte_sum);
            if (list_len == 0 || list_len > MAX_RANGES
                    || taken_start_q.size() >= int'(list_len))
                return ST_COUNT;
            if (blen == 0 || blen != alen)
                return ST_LENGTHS;
            if (blen > MAX_RANGE_BYTES || start % SECTOR_BYTES != 0
                    || blen % SECTOR_BYTES != 0
                    || start > dev_bytes || blen > dev_bytes - start)
                return ST_BOUNDS;
            if (w.label_len > MAX_LABEL_BYTES)
                return ST_LABEL;
            if (blen > MAX_TOTAL_BYTES || sum > MAX_TOTAL_BYTES - blen)
                return ST_TOTAL;
            stop = start + blen;
            foreach (taken_start_q[k])
                if (start < taken_stop_q[k] && taken_start_q[k] < stop)
                    return ST_OVERLAP;
            return ST_OK;
        endfunction

        function void note_range(range_word_t w);
            status_t        st;
            range_verdict_t v;
            ranges_seen++;
            if (w.first_of_list)
            begin
                taken_start_q.delete();
                taken_stop_q.delete();
                byte_sum    = '0;
                list_failed = 1'b0;
                lists_seen++;
            end
            if (list_failed)
                st = ST_SKIPPED;
            else
            begin
                st = judge_range(w);
                if (st == ST_OK)
                begin
                    taken_start_q = {taken_start_q, w.range_offset};
                    taken_stop_q  = {taken_stop_q, w.range_offset + 64'(w.before_length)};
                    byte_sum = byte_sum + TOTAL_W'(w.before_length);
                end
                else
                    list_failed = 1'b1;
            end
            v.status  = st;
            v.total   = byte_sum;
            verdict_q = {verdict_q, v};
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_verdict(logic [2:0] status, logic [TOTAL_W-1:0] total);
            range_verdict_t want;
            if (verdict_q.size() == 0)
            begin
                report_mismatch($sformatf("result with no range pending: status %0d total %0d",
                                          status, total));
                return;
            end
            want = verdict_q.pop_front();
            status_hits[want.status]++;
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d (%s)",
                                          status, want.status, want.status.name()));
            if (total !== want.total)
                report_mismatch($sformatf("captured_total %0d, want %0d", total, want.total));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    wrlv_item_if   item_bus();
    wrlv_result_if result_bus();

    range_list_tracker tracker = new();

    bit calm_tail = 1'b0;
    bit pressed   = 1'b0;
    int stall_cycles = 0;
    int random_sent  = 0;

    write_range_list_validator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_item (item_bus),
        .out_res (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: drop ready now and then for a random stretch, none in the tail.
    initial
    begin
        result_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm_tail && $urandom_range(0, 4) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            tracker.check_verdict(result_bus.status, result_bus.captured_total);
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t no word moved for %0d cycles", $time, stall_cycles);
            $display("[write_range_list_validator] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic range_word_t make_range(bit first, logic [63:0] off,
                                               logic [31:0] blen, logic [31:0] alen,
                                               logic [15:0] lab);
        range_word_t w;
        w.first_of_list = first;
        w.range_offset  = off;
        w.before_length = blen;
        w.after_length  = alen;
        w.label_len     = lab;
        return w;
    endfunction

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every owed verdict is back.
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [63:0] dev, logic [15:0] cnt);
        wait_drained();
        apb_write({REG_DEVICE_SIZE, 3'b000}, dev);
        apb_write({REG_RANGE_COUNT, 3'b000}, {48'b0, cnt});
        tracker.dev_bytes = dev;
        tracker.list_len  = cnt;
        tracker.settings_used++;
    endtask

    task automatic send_range(range_word_t w, bit calm);
        int gap;
        gap = (calm || calm_tail || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.first_of_list <= w.first_of_list;
        item_bus.range_offset  <= w.range_offset;
        item_bus.before_length <= w.before_length;
        item_bus.after_length  <= w.after_length;
        item_bus.label_len     <= w.label_len;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        tracker.note_range(w);
    endtask

    // Mostly well-formed lists packed upward from a random base, with noise mixed in.
    task automatic run_random_list(int n, bit big);
        range_word_t w;
        logic [63:0] cursor;
        logic [63:0] span;
        logic [31:0] blen;
        logic [15:0] lab;
        logic [63:0] prev_off[$];
        logic [31:0] prev_len[$];
        int          pick;
        int          k;
        int          i;
        bit          calm;
        calm = ($urandom_range(0, 3) == 0);
        span = (tracker.dev_bytes > 64'h1_0000_0000)
             ? tracker.dev_bytes - 64'h1_0000_0000 : tracker.dev_bytes >> 1;
        cursor = (rand64() % (span + 64'd1)) & ~64'h1FF;
        for (i = 0; i < n; i++)
        begin
            blen = big ? 32'(SECTOR_BYTES * $urandom_range(1, MAX_RANGE_BYTES / SECTOR_BYTES))
                       : 32'(SECTOR_BYTES * $urandom_range(1, 16));
            lab  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4090, 4100))
                                               : 16'($urandom_range(0, 600));
            cursor = cursor + 64'(SECTOR_BYTES * $urandom_range(0, 3));
            w = make_range((i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0,
                           cursor, blen, blen, lab);
            pick = $urandom_range(0, 99);
            if (pick < 6 && prev_off.size() > 0)
            begin
                // land inside an earlier range of this list
                k = $urandom_range(0, prev_off.size() - 1);
                w.range_offset = prev_off[k] + 64'(SECTOR_BYTES
                               * $urandom_range(0, prev_len[k] / SECTOR_BYTES - 1));
            end
            else if (pick < 14)
                w = make_range(1'($urandom_range(0, 1)), rand64(), $urandom, $urandom,
                               16'($urandom));
            else if (pick < 17)
                w.after_length = $urandom_range(0, 1) ? $urandom : blen + SECTOR_BYTES;
            else if (pick < 20)
                w.range_offset = cursor | 64'($urandom_range(1, SECTOR_BYTES - 1));
            else if (pick < 22)
                w.label_len = 16'($urandom);
            else if (pick < 23)
            begin
                w.before_length = '0;
                w.after_length  = '0;
            end
            else
            begin
                prev_off = {prev_off, cursor};
                prev_len = {prev_len, blen};
                cursor = cursor + 64'(blen);
            end
            if (i > 0 && i == n / 2 && (!pressed || $urandom_range(0, 19) == 0))
            begin
                wait_drained();
                pressed = 1'b1;
            end
            send_range(w, calm);
        end
    endtask

    initial
    begin
        logic [63:0] dev;
        logic [15:0] cnt;
        int          n;

        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        item_bus.valid         <= 1'b0;
        item_bus.first_of_list <= 1'b0;
        item_bus.range_offset  <= '0;
        item_bus.before_length <= '0;
        item_bus.after_length  <= '0;
        item_bus.label_len     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no list opened yet and a zero-size device.
        send_range(make_range(1'b0, 64'd0, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd0, 32'd512, 32'd512, 16'd0), 1'b0);

        configure('1, 16'd0);
        send_range(make_range(1'b1, 64'd0, 32'd512, 32'd512, 16'd0), 1'b0);
        configure('1, 16'hFFFF);
        send_range(make_range(1'b1, 64'd0, 32'd512, 32'd512, 16'd0), 1'b0);

        configure('1, 16'(MAX_RANGES));
        send_range(make_range(1'b1, 64'd0, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd512, 32'd0, 32'd0, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'd0, 32'd1024, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'd1, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'd0, 32'd513, 32'd513, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'd0, 32'(MAX_RANGE_BYTES + SECTOR_BYTES),
                              32'(MAX_RANGE_BYTES + SECTOR_BYTES), 16'd0), 1'b0);
        send_range(make_range(1'b1, '1, '1, '1, '1), 1'b0);
        // last sector of the device is one byte short
        send_range(make_range(1'b1, 64'hFFFF_FFFF_FFFF_FE00, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'hFFFF_FFFF_FFFF_FC00, 32'd512, 32'd512,
                              16'(MAX_LABEL_BYTES)), 1'b0);
        send_range(make_range(1'b0, 64'd0, 32'd512, 32'd512, 16'(MAX_LABEL_BYTES + 1)), 1'b0);
        // fill the byte budget exactly, then go one sector over
        for (int r = 0; r < 4; r++)
            send_range(make_range(r == 0, 64'(r * MAX_RANGE_BYTES), 32'(MAX_RANGE_BYTES),
                                  32'(MAX_RANGE_BYTES), 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'(MAX_TOTAL_BYTES), 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'd0, 32'd4096, 32'd4096, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd2048, 32'd4096, 32'd4096, 16'd0), 1'b0);
        send_range(make_range(1'b1, 64'd4096, 32'd4096, 32'd4096, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd0, 32'd4096, 32'd4096, 16'd0), 1'b0);

        configure('1, 16'd2);
        send_range(make_range(1'b1, 64'd0, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd512, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd1024, 32'd512, 32'd512, 16'd0), 1'b0);
        send_range(make_range(1'b0, 64'd1536, 32'd512, 32'd512, 16'd0), 1'b0);

        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       dev = '0;
                1, 2:    dev = 64'd1 << $urandom_range(12, 30);
                3, 4, 5: dev = rand64();
                default: dev = '1;
            endcase
            case ($urandom_range(0, 9))
                0:       cnt = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                1, 2, 3: cnt = 16'($urandom_range(1, 10));
                4:       cnt = 16'hFFFF;
                default: cnt = 16'(MAX_RANGES);
            endcase
            configure(dev, cnt);
            repeat ($urandom_range(2, 4))
            begin
                if (random_sent < RANDOM_ITEMS)
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
                    run_random_list(n, $urandom_range(0, 6) == 0);
                    random_sent += n;
                    calm_tail = (random_sent >= RANDOM_ITEMS - 25);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d ranges in %0d lists over %0d register settings",
                 tracker.ranges_seen, tracker.lists_seen, tracker.settings_used);
        $display("verdicts: ok %0d count %0d lengths %0d bounds %0d label %0d total %0d %s %0d",
                 tracker.status_hits[ST_OK], tracker.status_hits[ST_COUNT],
                 tracker.status_hits[ST_LENGTHS], tracker.status_hits[ST_BOUNDS],
                 tracker.status_hits[ST_LABEL], tracker.status_hits[ST_TOTAL],
                 $sformatf("overlap %0d skipped", tracker.status_hits[ST_OVERLAP]),
                 tracker.status_hits[ST_SKIPPED]);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[write_range_list_validator] OK");
        else
            $display("[write_range_list_validator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
